/* sv/pie_pkg.sv */
`default_nettype none

package pie_pkg;

    localparam int COORD_BITS = 20;
    localparam int RAD_BITS   = COORD_BITS - 1;
    localparam int HALF_W     = COORD_BITS;
    localparam int OPD_W      = 2 * HALF_W;
    localparam int SQ_W       = OPD_W + 1;
    localparam int ACC_W      = 4 * HALF_W;
    localparam int SHIFT_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int DIST_CELLS = 2;
    localparam int PROD_CELLS = 4;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [HALF_W-1:0]     half_t;
    typedef logic [OPD_W-1:0]      opd_t;
    typedef logic [ACC_W-1:0]      acc_t;

    typedef struct packed {
        logic               sel_x;
        logic               sel_y;
        logic [SHIFT_W-1:0] shift;
    } mac_ctrl_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCUS_A_X    = 3'd0,
        REG_FOCUS_A_Y    = 3'd1,
        REG_FOCUS_B_X    = 3'd2,
        REG_FOCUS_B_Y    = 3'd3,
        REG_MAJOR_RADIUS = 3'd4
    } cfg_reg_t;

    // Operands carry two halves: the squared distance adds dy*dy to dx*dx,
    // the wide product sums the four half products at their weights.
    localparam mac_ctrl_t DIST_CTRL [DIST_CELLS] = '{
        '{sel_x: 1'b0, sel_y: 1'b0, shift: 2'd0},
        '{sel_x: 1'b1, sel_y: 1'b1, shift: 2'd0}
    };

    localparam mac_ctrl_t PROD_CTRL [PROD_CELLS] = '{
        '{sel_x: 1'b0, sel_y: 1'b0, shift: 2'd0},
        '{sel_x: 1'b0, sel_y: 1'b1, shift: 2'd1},
        '{sel_x: 1'b1, sel_y: 1'b0, shift: 2'd1},
        '{sel_x: 1'b1, sel_y: 1'b1, shift: 2'd2}
    };

endpackage

`default_nettype wire

/* sv/pie_mac_cell.sv */
`default_nettype none

module pie_mac_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire pie_pkg::mac_ctrl_t ctrl,
    input  wire logic              valid_in,
    input  wire pie_pkg::opd_t     x_in,
    input  wire pie_pkg::opd_t     y_in,
    input  wire pie_pkg::acc_t     acc_in,
    output logic                   valid_out,
    output pie_pkg::opd_t          x_out,
    output pie_pkg::opd_t          y_out,
    output pie_pkg::acc_t          acc_out
);

    logic           valid_reg;
    pie_pkg::opd_t  x_reg;
    pie_pkg::opd_t  y_reg;
    pie_pkg::acc_t  acc_reg;
    pie_pkg::half_t x_half;
    pie_pkg::half_t y_half;
    pie_pkg::opd_t  prod;
    pie_pkg::acc_t  term;
    pie_pkg::acc_t  acc_next;

    always_comb begin
        x_half = ctrl.sel_x ? x_in[pie_pkg::OPD_W-1:pie_pkg::HALF_W]
                            : x_in[pie_pkg::HALF_W-1:0];
        y_half = ctrl.sel_y ? y_in[pie_pkg::OPD_W-1:pie_pkg::HALF_W]
                            : y_in[pie_pkg::HALF_W-1:0];
        prod   = {pie_pkg::HALF_W'(0), x_half} * {pie_pkg::HALF_W'(0), y_half};
        case (ctrl.shift)
            2'd0:    term = pie_pkg::ACC_W'(prod);
            2'd1:    term = pie_pkg::ACC_W'(prod) << pie_pkg::HALF_W;
            2'd2:    term = pie_pkg::ACC_W'(prod) << (2 * pie_pkg::HALF_W);
            default: term = '0;
        endcase
        acc_next = acc_in + term;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg   <= x_in;
            y_reg   <= y_in;
            acc_reg <= acc_next;
        end
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign acc_out   = acc_reg;

endmodule

`default_nettype wire

/* sv/point_in_ellipse_test_unit.sv */
// Throughput: one point per cycle; the pipeline is a row of multiply-accumulate
// cells with one 20x20 multiplier each, and the whole row holds while a result waits.
// Reset: synchronous, active low; clears all valid flags and sets every focus and
// radius register to zero.
`default_nettype none

module point_in_ellipse_test_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [pie_pkg::COORD_BITS-1:0]    s_point_x,
    input  wire logic [pie_pkg::COORD_BITS-1:0]    s_point_y,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_inside_res,
    input  wire logic                              cfg_we,
    input  wire logic [pie_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  wire logic [pie_pkg::COORD_BITS-1:0]    cfg_data
);

    localparam int NP = pie_pkg::PROD_CELLS;

    function automatic pie_pkg::half_t abs_diff(input pie_pkg::coord_t p,
                                                input pie_pkg::coord_t q);
        logic [pie_pkg::COORD_BITS:0] d;
        logic [pie_pkg::COORD_BITS:0] n;
        d = {p[pie_pkg::COORD_BITS-1], p} - {q[pie_pkg::COORD_BITS-1], q};
        n = -d;
        return d[pie_pkg::COORD_BITS] ? n[pie_pkg::HALF_W-1:0] : d[pie_pkg::HALF_W-1:0];
    endfunction

    logic                           adv;
    pie_pkg::coord_t                focus_a_x_reg;
    pie_pkg::coord_t                focus_a_y_reg;
    pie_pkg::coord_t                focus_b_x_reg;
    pie_pkg::coord_t                focus_b_y_reg;
    logic [pie_pkg::RAD_BITS-1:0]   major_radius_reg;
    pie_pkg::half_t                 rad2;
    pie_pkg::opd_t                  s2_reg;
    pie_pkg::opd_t                  s2_next;

    logic                           v1_reg;
    pie_pkg::half_t                 dxa_reg, dya_reg, dxb_reg, dyb_reg;

    logic                           da_v0, da_v1, db_v0, db_v1;
    pie_pkg::opd_t                  da_x0, da_y0, db_x0, db_y0;
    pie_pkg::acc_t                  da_acc0, da_acc1, db_acc0, db_acc1;

    logic [pie_pkg::SQ_W-1:0]       da, db;
    logic [pie_pkg::SQ_W:0]         dsum;
    logic                           v4_reg;
    logic                           ok4_reg;
    pie_pkg::opd_t                  da_reg, db_reg, c_reg, c_next;

    logic                           ab_valid [NP+1];
    logic                           cc_valid [NP+1];
    pie_pkg::opd_t                  ab_x [NP];
    pie_pkg::opd_t                  ab_y [NP];
    pie_pkg::opd_t                  cc_x [NP];
    pie_pkg::opd_t                  cc_y [NP];
    pie_pkg::acc_t                  ab_acc [NP+1];
    pie_pkg::acc_t                  cc_acc [NP+1];
    logic                           ok_pipe_reg [NP];

    logic                           m_valid_reg;
    logic                           m_inside_reg;
    logic                           inside_next;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focus_a_x_reg    <= '0;
            focus_a_y_reg    <= '0;
            focus_b_x_reg    <= '0;
            focus_b_y_reg    <= '0;
            major_radius_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                pie_pkg::REG_FOCUS_A_X:    focus_a_x_reg    <= cfg_data;
                pie_pkg::REG_FOCUS_A_Y:    focus_a_y_reg    <= cfg_data;
                pie_pkg::REG_FOCUS_B_X:    focus_b_x_reg    <= cfg_data;
                pie_pkg::REG_FOCUS_B_Y:    focus_b_y_reg    <= cfg_data;
                pie_pkg::REG_MAJOR_RADIUS: major_radius_reg <= cfg_data[pie_pkg::RAD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // The squared major axis is registered from the radius register and follows it in the next cycle.
    assign rad2    = {major_radius_reg, 1'b0};
    assign s2_next = {pie_pkg::HALF_W'(0), rad2} * {pie_pkg::HALF_W'(0), rad2};

    always_ff @(posedge aclk) begin
        s2_reg <= s2_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dxa_reg <= abs_diff(s_point_x, focus_a_x_reg);
            dya_reg <= abs_diff(s_point_y, focus_a_y_reg);
            dxb_reg <= abs_diff(s_point_x, focus_b_x_reg);
            dyb_reg <= abs_diff(s_point_y, focus_b_y_reg);
        end
    end

    pie_mac_cell u_da0 (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .ctrl(pie_pkg::DIST_CTRL[0]),
        .valid_in(v1_reg), .x_in({dya_reg, dxa_reg}), .y_in({dya_reg, dxa_reg}),
        .acc_in('0), .valid_out(da_v0), .x_out(da_x0), .y_out(da_y0), .acc_out(da_acc0)
    );

    pie_mac_cell u_da1 (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .ctrl(pie_pkg::DIST_CTRL[1]),
        .valid_in(da_v0), .x_in(da_x0), .y_in(da_y0),
        .acc_in(da_acc0), .valid_out(da_v1), .x_out(), .y_out(), .acc_out(da_acc1)
    );

    pie_mac_cell u_db0 (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .ctrl(pie_pkg::DIST_CTRL[0]),
        .valid_in(v1_reg), .x_in({dyb_reg, dxb_reg}), .y_in({dyb_reg, dxb_reg}),
        .acc_in('0), .valid_out(db_v0), .x_out(db_x0), .y_out(db_y0), .acc_out(db_acc0)
    );

    pie_mac_cell u_db1 (
        .aclk(aclk), .aresetn(aresetn), .en(adv), .ctrl(pie_pkg::DIST_CTRL[1]),
        .valid_in(db_v0), .x_in(db_x0), .y_in(db_y0),
        .acc_in(db_acc0), .valid_out(db_v1), .x_out(), .y_out(), .acc_out(db_acc1)
    );

    // Both focal distances fit when their squares sum to at most S*S; then the
    // remaining test is 4*A*B <= (S*S - A - B)^2.
    assign da     = da_acc1[pie_pkg::SQ_W-1:0];
    assign db     = db_acc1[pie_pkg::SQ_W-1:0];
    assign dsum   = {1'b0, da} + {1'b0, db};
    assign c_next = s2_reg - da[pie_pkg::OPD_W-1:0] - db[pie_pkg::OPD_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= da_v1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ok4_reg <= (dsum <= {2'b00, s2_reg});
            da_reg  <= da[pie_pkg::OPD_W-1:0];
            db_reg  <= db[pie_pkg::OPD_W-1:0];
            c_reg   <= c_next;
        end
    end

    assign ab_valid[0] = v4_reg;
    assign cc_valid[0] = v4_reg;
    assign ab_x[0]     = da_reg;
    assign ab_y[0]     = db_reg;
    assign cc_x[0]     = c_reg;
    assign cc_y[0]     = c_reg;
    assign ab_acc[0]   = '0;
    assign cc_acc[0]   = '0;

    for (genvar k = 0; k < NP; k++) begin : g_prod
        if (k < NP - 1) begin : g_mid
            pie_mac_cell u_ab (
                .aclk(aclk), .aresetn(aresetn), .en(adv), .ctrl(pie_pkg::PROD_CTRL[k]),
                .valid_in(ab_valid[k]), .x_in(ab_x[k]), .y_in(ab_y[k]),
                .acc_in(ab_acc[k]), .valid_out(ab_valid[k+1]), .x_out(ab_x[k+1]),
                .y_out(ab_y[k+1]), .acc_out(ab_acc[k+1])
            );
            pie_mac_cell u_cc (
                .aclk(aclk), .aresetn(aresetn), .en(adv), .ctrl(pie_pkg::PROD_CTRL[k]),
                .valid_in(cc_valid[k]), .x_in(cc_x[k]), .y_in(cc_y[k]),
                .acc_in(cc_acc[k]), .valid_out(cc_valid[k+1]), .x_out(cc_x[k+1]),
                .y_out(cc_y[k+1]), .acc_out(cc_acc[k+1])
            );
        end else begin : g_last
            pie_mac_cell u_ab (
                .aclk(aclk), .aresetn(aresetn), .en(adv), .ctrl(pie_pkg::PROD_CTRL[k]),
                .valid_in(ab_valid[k]), .x_in(ab_x[k]), .y_in(ab_y[k]),
                .acc_in(ab_acc[k]), .valid_out(ab_valid[k+1]), .x_out(),
                .y_out(), .acc_out(ab_acc[k+1])
            );
            pie_mac_cell u_cc (
                .aclk(aclk), .aresetn(aresetn), .en(adv), .ctrl(pie_pkg::PROD_CTRL[k]),
                .valid_in(cc_valid[k]), .x_in(cc_x[k]), .y_in(cc_y[k]),
                .acc_in(cc_acc[k]), .valid_out(cc_valid[k+1]), .x_out(),
                .y_out(), .acc_out(cc_acc[k+1])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ok_pipe_reg[0] <= ok4_reg;
            for (int i = 1; i < NP; i++) begin
                ok_pipe_reg[i] <= ok_pipe_reg[i-1];
            end
        end
    end

    assign inside_next = ok_pipe_reg[NP-1] && ({ab_acc[NP], 2'b00} <= {2'b00, cc_acc[NP]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= ab_valid[NP];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_inside_reg <= inside_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_inside_res = m_inside_reg;

    a_lanes_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        (da_v1 == db_v1) && (ab_valid[NP] == cc_valid[NP]))
        else $error("Parallel cell lanes lost step.");

    a_outside_when_too_far: assert property (@(posedge aclk) disable iff (!aresetn)
        (ab_valid[NP] && adv && !ok_pipe_reg[NP-1]) |=> (m_valid && !m_inside_res))
        else $error("Point beyond the focal sum bound reported inside.");

    a_result_has_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(ab_valid[NP]))
        else $error("Result appeared without a request in the last cell.");

    a_row_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> ($stable(v1_reg) && $stable(v4_reg)))
        else $error("Pipeline moved while the output was stalled.");

endmodule

`default_nettype wire
